[src/tfsa_pkg.sv]
// tfsa_pkg: shared types, constants and helpers for the telemetry frame block
// used by every module of the block; depends on nothing
`default_nettype none

package tfsa_pkg;

	localparam int NUM_VALUES  = 6;
	localparam int VALUE_W     = 16;
	localparam int PAYLOAD_W   = NUM_VALUES * VALUE_W;
	localparam int FRAME_BYTES = 18;
	localparam int HDR_BYTES   = 4;
	localparam int IDX_W       = $clog2(FRAME_BYTES);
	localparam int PIDX_W      = $clog2(NUM_VALUES * 2);
	localparam int CFG_IDX_W   = 8;
	localparam int WT_W        = 4;

	localparam logic [7:0] FRAME_HEADER = 8'hAA;
	localparam logic [7:0] FRAME_LENGTH = 8'h0C;
	localparam logic [7:0] DEST_RESET   = 8'hFF;
	localparam logic [7:0] FUNC_RESET   = 8'hF1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEST = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FUNC = 8'd1;

	// byte positions inside a frame
	localparam logic [IDX_W-1:0] IDX_HDR       = 5'd0;
	localparam logic [IDX_W-1:0] IDX_DEST      = 5'd1;
	localparam logic [IDX_W-1:0] IDX_FUNC      = 5'd2;
	localparam logic [IDX_W-1:0] IDX_LEN       = 5'd3;
	localparam logic [IDX_W-1:0] IDX_PAY_FIRST = 5'd4;
	localparam logic [IDX_W-1:0] IDX_PAY_LAST  = 5'd15;
	localparam logic [IDX_W-1:0] IDX_SUM       = 5'd16;
	localparam logic [IDX_W-1:0] IDX_ADD       = 5'd17;

	// add check weights of the header bytes: a byte at position k counts 16-k times
	localparam logic [WT_W:0] WT_HDR  = 5'd16;
	localparam logic [WT_W:0] WT_DEST = 5'd15;
	localparam logic [WT_W:0] WT_FUNC = 5'd14;
	localparam logic [WT_W:0] WT_LEN  = 5'd13;

	typedef struct packed {
		logic [7:0] sum;
		logic [7:0] add;
	} lane_res_t;

	typedef struct packed {
		logic [7:0]           dest;
		logic [7:0]           func;
		logic [PAYLOAD_W-1:0] payload;
		logic [7:0]           sum;
		logic [7:0]           add;
	} frame_t;

	// value i sits at bytes 4+2i (low) and 5+2i (high)
	function automatic logic [WT_W-1:0] lo_weight(input int i);
		return WT_W'(12 - 2 * i);
	endfunction

	function automatic logic [WT_W-1:0] hi_weight(input int i);
		return WT_W'(11 - 2 * i);
	endfunction

endpackage

`default_nettype wire

[src/tfsa_lane.sv]
// tfsa_lane: sum and weighted add check contribution of one telemetry value
// depends on tfsa_pkg
`default_nettype none

module tfsa_lane
	import tfsa_pkg::*;
(
	input  wire logic [VALUE_W-1:0] value,
	input  wire logic [WT_W-1:0]    lo_wt,
	input  wire logic [WT_W-1:0]    hi_wt,
	output lane_res_t               res
);

	logic [7:0]        lo_b;
	logic [7:0]        hi_b;
	logic [7+WT_W:0]   lo_prod;
	logic [7+WT_W:0]   hi_prod;

	always_comb begin
		lo_b    = value[7:0];
		hi_b    = value[15:8];
		lo_prod = {{WT_W{1'b0}}, lo_b} * {8'd0, lo_wt};
		hi_prod = {{WT_W{1'b0}}, hi_b} * {8'd0, hi_wt};
		res.sum = lo_b + hi_b;
		res.add = lo_prod[7:0] + hi_prod[7:0];
	end

endmodule

`default_nettype wire

[src/tfsa_merge.sv]
// tfsa_merge: folds header bytes and lane results into the two check bytes
// depends on tfsa_pkg
`default_nettype none

module tfsa_merge
	import tfsa_pkg::*;
(
	input  wire lane_res_t  lanes [NUM_VALUES],
	input  wire logic [7:0] dest,
	input  wire logic [7:0] func,
	output logic [7:0]      sum,
	output logic [7:0]      add
);

	logic [7+WT_W+1:0] p_hdr;
	logic [7+WT_W+1:0] p_dest;
	logic [7+WT_W+1:0] p_func;
	logic [7+WT_W+1:0] p_len;
	logic [7:0]        acc_sum;
	logic [7:0]        acc_add;

	always_comb begin
		p_hdr   = {5'd0, FRAME_HEADER} * {8'd0, WT_HDR};
		p_dest  = {5'd0, dest} * {8'd0, WT_DEST};
		p_func  = {5'd0, func} * {8'd0, WT_FUNC};
		p_len   = {5'd0, FRAME_LENGTH} * {8'd0, WT_LEN};
		acc_sum = FRAME_HEADER + dest + func + FRAME_LENGTH;
		acc_add = p_hdr[7:0] + p_dest[7:0] + p_func[7:0] + p_len[7:0];
		for (int i = 0; i < NUM_VALUES; i++) begin
			acc_sum = acc_sum + lanes[i].sum;
			acc_add = acc_add + lanes[i].add;
		end
		sum = acc_sum;
		add = acc_add;
	end

endmodule

`default_nettype wire

[src/tfsa_ser.sv]
// tfsa_ser: frame register and byte serializer with registered output word
// depends on tfsa_pkg
`default_nettype none

module tfsa_ser
	import tfsa_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   load_req,
	input  wire frame_t frame_in,
	output logic        load_ack,
	output logic        out_valid,
	input  wire logic   out_stall,
	output logic [7:0]  frame_byte,
	output logic        last_byte
);

	frame_t            frame_q;
	logic              busy_q;
	logic [IDX_W-1:0]  idx_q;
	logic              out_valid_q;
	logic [7:0]        byte_q;
	logic              last_q;

	logic              emit;
	logic              finishing;
	logic [7:0]        cur_byte;
	logic [PIDX_W-1:0] pidx;

	assign emit      = busy_q && (!out_valid_q || !out_stall);
	assign finishing = emit && (idx_q == IDX_ADD);
	assign load_ack  = load_req && (!busy_q || finishing);

	always_comb begin
		pidx = PIDX_W'(idx_q - IDX_PAY_FIRST);
		case (idx_q) inside
			IDX_HDR:  cur_byte = FRAME_HEADER;
			IDX_DEST: cur_byte = frame_q.dest;
			IDX_FUNC: cur_byte = frame_q.func;
			IDX_LEN:  cur_byte = FRAME_LENGTH;
			[IDX_PAY_FIRST:IDX_PAY_LAST]: cur_byte = frame_q.payload[{pidx, 3'b000} +: 8];
			IDX_SUM:  cur_byte = frame_q.sum;
			IDX_ADD:  cur_byte = frame_q.add;
			default:  cur_byte = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load_ack) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (finishing) begin
			busy_q <= 1'b0;
		end else if (emit) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_ack) begin
			frame_q <= frame_in;
		end
		if (emit) begin
			byte_q <= cur_byte;
			last_q <= (idx_q == IDX_ADD);
		end
	end

	// output word register, refilled in the cycle it is taken while a frame is being sent
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_byte = byte_q;
	assign last_byte  = last_q;

endmodule

`default_nettype wire

[src/telemetry_frame_with_sum_add_check_unit.sv]
// telemetry_frame_with_sum_add_check_unit: top level, six value lanes, merge and serializer
// depends on tfsa_pkg, tfsa_lane, tfsa_merge, tfsa_ser
//
//   port group   dir   handshake             carries
//   input        in    in_valid / in_stall   value_a .. value_f
//   output       out   out_valid / out_stall frame_byte, last_byte
//   config       in    cfg_valid / cfg_ready cfg_index, cfg_data
//
// one word out per cycle while out_stall is low, as the serializer emits a single output byte;
// a new item can be taken while the previous frame is still being sent
// an accepted item waits in the lane stage while the previous frame drains, so frames leave
// back to back; an item goes through the lane stage and frame register to the output word
// out_stall holds the output word and the serializer; in_stall: lane stage full and not loaded
// reset restores dest_addr 0xff and func_code 0xf1 and empties every stage
`default_nettype none

module telemetry_frame_with_sum_add_check_unit
	import tfsa_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic signed [15:0]   value_a,
	input  wire logic signed [15:0]   value_b,
	input  wire logic signed [15:0]   value_c,
	input  wire logic signed [15:0]   value_d,
	input  wire logic signed [15:0]   value_e,
	input  wire logic signed [15:0]   value_f,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [7:0]                frame_byte,
	output logic                      last_byte,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]           cfg_data
);

	logic [7:0]           dest_addr_q;
	logic [7:0]           func_code_q;

	logic [VALUE_W-1:0]   values [NUM_VALUES];
	lane_res_t            lane_res [NUM_VALUES];

	logic                 valid_s1;
	lane_res_t            lanes_s1 [NUM_VALUES];
	logic [PAYLOAD_W-1:0] payload_s1;
	logic [7:0]           dest_s1;
	logic [7:0]           func_s1;

	logic                 accept;
	logic                 load_ack;
	frame_t               frame;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_addr_q <= DEST_RESET;
			func_code_q <= FUNC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DEST: dest_addr_q <= cfg_data;
				REG_FUNC: func_code_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign values[0] = value_a;
	assign values[1] = value_b;
	assign values[2] = value_c;
	assign values[3] = value_d;
	assign values[4] = value_e;
	assign values[5] = value_f;

	for (genvar i = 0; i < NUM_VALUES; i++) begin : g_lane
		tfsa_lane u_lane (
			.value (values[i]),
			.lo_wt (lo_weight(i)),
			.hi_wt (hi_weight(i)),
			.res   (lane_res[i])
		);
	end

	assign in_stall = valid_s1 && !load_ack;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (load_ack) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lanes_s1   <= lane_res;
			payload_s1 <= {value_f, value_e, value_d, value_c, value_b, value_a};
			dest_s1    <= dest_addr_q;
			func_s1    <= func_code_q;
		end
	end

	tfsa_merge u_merge (
		.lanes (lanes_s1),
		.dest  (dest_s1),
		.func  (func_s1),
		.sum   (frame.sum),
		.add   (frame.add)
	);

	assign frame.dest    = dest_s1;
	assign frame.func    = func_s1;
	assign frame.payload = payload_s1;

	tfsa_ser u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_req   (valid_s1),
		.frame_in   (frame),
		.load_ack   (load_ack),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.frame_byte (frame_byte),
		.last_byte  (last_byte)
	);

endmodule

`default_nettype wire
